// ===== hw/rtl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants, codes and types of the three-phase commit engine.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int MAX_NODES   = 16;
   localparam int ACT_W       = 2;
   localparam int TAG_W       = 3;
   localparam int NODE_W      = 4;
   localparam int CNT_W       = 4;
   localparam int TICK_W      = 16;
   localparam int TIMER_W     = 20;
   localparam int PHASE_W     = 3;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;

   // actions
   localparam logic [ACT_W-1:0] ACT_START = 2'd0;
   localparam logic [ACT_W-1:0] ACT_MSG   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

   // message tags
   localparam logic [TAG_W-1:0] TAG_CAN_COMMIT = 3'd0;
   localparam logic [TAG_W-1:0] TAG_VOTE_YES   = 3'd1;
   localparam logic [TAG_W-1:0] TAG_ABORT      = 3'd2;
   localparam logic [TAG_W-1:0] TAG_PREPARE    = 3'd3;
   localparam logic [TAG_W-1:0] TAG_ACK        = 3'd4;
   localparam logic [TAG_W-1:0] TAG_COMMIT     = 3'd5;

   localparam logic [NODE_W-1:0] COORD_NODE = 4'd0;

   // protocol phases
   localparam logic [PHASE_W-1:0] PH_QUERY     = 3'd0;
   localparam logic [PHASE_W-1:0] PH_WAITING   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PRECOMMIT = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ABORT     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_COMMIT    = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ROLE          = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COHORT_COUNT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic                ROLE_COORD   = 1'b0;
   localparam logic [CNT_W-1:0]    COHORT_RESET = 4'd1;
   localparam logic [TICK_W-1:0]   TICKS_RESET  = 16'd4000;

   // one queued job for the output side
   typedef struct packed {
      logic               send_valid;
      logic               bcast;
      logic [TAG_W-1:0]   tag;
      logic [CNT_W-1:0]   count;
      logic [PHASE_W-1:0] node_state;
   } cmd_type;

endpackage

// ===== hw/rtl/tpc_if.sv =====
// ----------------------------------------------------------------------------
// tpc_if
// Valid/ready channels of the commit engine: events, results, registers.
// ----------------------------------------------------------------------------
interface tpc_req_if;
   logic                   valid;
   logic                   ready;
   logic [tpc_pkg::ACT_W-1:0]  action;
   logic [tpc_pkg::TAG_W-1:0]  msg_tag;
   logic [tpc_pkg::NODE_W-1:0] msg_source;

   modport source (output valid, action, msg_tag, msg_source, input ready);
   modport sink   (input valid, action, msg_tag, msg_source, output ready);
endinterface

interface tpc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        send_valid;
   logic [tpc_pkg::TAG_W-1:0]   send_tag;
   logic [tpc_pkg::NODE_W-1:0]  send_to;
   logic [tpc_pkg::PHASE_W-1:0] node_state;
   logic                        last;

   modport source (output valid, send_valid, send_tag, send_to, node_state, last,
                   input ready);
   modport sink   (input valid, send_valid, send_tag, send_to, node_state, last,
                   output ready);
endinterface

interface tpc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tpc_pkg::CSR_ADDR_W-1:0] addr;
   logic [tpc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/tpc_front.sv =====
// ----------------------------------------------------------------------------
// tpc_front
// Register file, protocol state and event classification. Each accepted
// event updates the phase at once and queues one job for the output side.
// ----------------------------------------------------------------------------
module tpc_front (
   input  logic             clock,
   input  logic             reset,
   tpc_req_if.sink          req_ch,
   tpc_csr_if.sink          csr_ch,
   input  logic             q_full,
   output logic             q_push,
   output tpc_pkg::cmd_type q_cmd
);
   import tpc_pkg::*;

   logic               role_ff;
   logic [CNT_W-1:0]   cohort_ff;
   logic [TICK_W-1:0]  ticks_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CNT_W-1:0]   ack_ff, ack_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;

   logic [CNT_W-1:0]   eff;
   logic [TIMER_W-1:0] limit;
   logic [TIMER_W-1:0] timer_inc;
   logic [CNT_W-1:0]   ack_inc;
   logic               take;
   logic               active;
   logic [TAG_W-1:0]   want;
   logic [TAG_W-1:0]   adv_tag;
   logic [PHASE_W-1:0] adv_phase;
   cmd_type            cmd;

   assign csr_ch.ready = !reset;
   assign req_ch.ready = !reset && !q_full;
   assign take         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff   <= ROLE_COORD;
         cohort_ff <= COHORT_RESET;
         ticks_ff  <= TICKS_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_ROLE:          role_ff   <= csr_ch.data[0];
            CSR_COHORT_COUNT:  cohort_ff <= csr_ch.data[CNT_W-1:0];
            CSR_TIMEOUT_TICKS: ticks_ff  <= csr_ch.data[TICK_W-1:0];
            default:           ;
         endcase
      end
   end

   // effective cohort count: zero reads as one, capped at MAX_NODES - 1
   always_comb begin
      eff = cohort_ff;
      if (eff == '0) eff = CNT_W'(1);
      if (int'(eff) > MAX_NODES - 1) eff = CNT_W'(MAX_NODES - 1);
   end

   assign limit     = TIMER_W'(ticks_ff) * TIMER_W'(eff);
   assign timer_inc = timer_ff + 1'b1;
   assign ack_inc   = ack_ff + 1'b1;
   assign active    = (phase_ff == PH_WAITING) || (phase_ff == PH_PRECOMMIT);
   assign want      = (phase_ff == PH_WAITING) ? TAG_VOTE_YES : TAG_ACK;
   assign adv_tag   = (phase_ff == PH_WAITING) ? TAG_PREPARE : TAG_COMMIT;
   assign adv_phase = (phase_ff == PH_WAITING) ? PH_PRECOMMIT : PH_COMMIT;

   always_comb begin
      phase_in = phase_ff;
      ack_in   = ack_ff;
      timer_in = timer_ff;
      cmd      = '0;
      if (role_ff == ROLE_COORD) begin
         if (phase_ff == PH_QUERY) begin
            if (req_ch.action == ACT_START) begin
               phase_in  = PH_WAITING;
               cmd.bcast = 1'b1;
               cmd.tag   = TAG_CAN_COMMIT;
            end
         end else if (active) begin
            if (req_ch.action == ACT_MSG) begin
               if (req_ch.msg_tag == want) begin
                  if (ack_inc >= eff) begin
                     phase_in  = adv_phase;
                     cmd.bcast = 1'b1;
                     cmd.tag   = adv_tag;
                  end else begin
                     ack_in = ack_inc;
                  end
               end else if (req_ch.msg_tag == TAG_ABORT) begin
                  phase_in  = PH_ABORT;
                  cmd.bcast = 1'b1;
                  cmd.tag   = TAG_ABORT;
               end
            end else if (req_ch.action == ACT_TICK) begin
               if (timer_inc >= limit) begin
                  phase_in  = PH_ABORT;
                  cmd.bcast = 1'b1;
                  cmd.tag   = TAG_ABORT;
               end else begin
                  timer_in = timer_inc;
               end
            end
         end
      end else if (active || phase_ff == PH_QUERY) begin
         if (req_ch.action == ACT_MSG) begin
            if (req_ch.msg_source == COORD_NODE) begin
               if (req_ch.msg_tag == TAG_ABORT) begin
                  phase_in = PH_ABORT;
               end else if (phase_ff == PH_QUERY && req_ch.msg_tag == TAG_CAN_COMMIT) begin
                  phase_in = PH_WAITING;
                  cmd.tag  = TAG_VOTE_YES;
               end else if (phase_ff == PH_WAITING && req_ch.msg_tag == TAG_PREPARE) begin
                  phase_in = PH_PRECOMMIT;
                  cmd.tag  = TAG_ACK;
               end else if (phase_ff == PH_PRECOMMIT && req_ch.msg_tag == TAG_COMMIT) begin
                  phase_in = PH_COMMIT;
               end
            end
         end else if (req_ch.action == ACT_TICK) begin
            if (timer_inc >= TIMER_W'(ticks_ff)) begin
               phase_in = (phase_ff == PH_PRECOMMIT) ? PH_COMMIT : PH_ABORT;
            end else begin
               timer_in = timer_inc;
            end
         end
      end
      // any phase change clears the counters
      if (phase_in != phase_ff) begin
         ack_in   = '0;
         timer_in = '0;
      end
      cmd.send_valid = cmd.bcast || (cmd.tag != TAG_CAN_COMMIT);
      cmd.count      = eff;
      cmd.node_state = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_QUERY;
         ack_ff   <= '0;
         timer_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         ack_ff   <= ack_in;
         timer_ff <= timer_in;
      end
   end

   assign q_push = take;
   assign q_cmd  = cmd;

endmodule

// ===== hw/rtl/tpc_queue.sv =====
// ----------------------------------------------------------------------------
// tpc_queue
// Short job queue between the event front and the result emitter.
// ----------------------------------------------------------------------------
module tpc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tpc_pkg::cmd_type push_cmd,
   input  logic             pop,
   output tpc_pkg::cmd_type pop_cmd,
   output logic             full,
   output logic             empty
);
   import tpc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [PTR_W:0]       cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full    = (cnt_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? PTR_W'((wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? 0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? PTR_W'((rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? 0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/tpc_back.sv =====
// ----------------------------------------------------------------------------
// tpc_back
// Result emitter: holds one job and walks a broadcast over the cohorts,
// one result per transfer.
// ----------------------------------------------------------------------------
module tpc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  tpc_pkg::cmd_type q_cmd,
   output logic             q_pop,
   tpc_rsp_if.source        rsp_ch
);
   import tpc_pkg::*;

   cmd_type          cur_ff;
   logic             busy_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             last_w;
   logic             xfer;
   logic             load;

   assign last_w = !cur_ff.bcast || (idx_ff == cur_ff.count);
   assign xfer   = busy_ff && rsp_ch.ready;
   assign load   = !busy_ff || (rsp_ch.ready && last_w);
   assign q_pop  = load && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_cmd;
         idx_ff <= CNT_W'(1);
      end else if (xfer) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign rsp_ch.valid      = busy_ff;
   assign rsp_ch.send_valid = cur_ff.send_valid;
   assign rsp_ch.send_tag   = cur_ff.send_valid ? cur_ff.tag : '0;
   assign rsp_ch.send_to    = cur_ff.bcast ? NODE_W'(idx_ff) : COORD_NODE;
   assign rsp_ch.node_state = cur_ff.node_state;
   assign rsp_ch.last       = last_w;

endmodule

// ===== hw/rtl/three_phase_commit_engine_top.sv =====
// ----------------------------------------------------------------------------
// three_phase_commit_engine_top
// One node of a three-phase commit protocol, coordinator or cohort.
// ----------------------------------------------------------------------------
// Channels: req_ch carries events (start, received message, timer tick),
// rsp_ch carries results, csr_ch writes role, cohort_count, timeout_ticks.
// Registers must be written only while the node is idle; the block itself
// does not enforce this. csr_ch is ready out of reset. In the front, phase,
// ack count and wait timer update at the event transfer and one job enters
// a four-entry queue; the job passes through the queue and then the emitter
// register before its result is valid on rsp_ch.
// Throughput: one event per cycle while rsp_ch is ready, when each gives one
// result (status or single send). A broadcast gives one result per cohort
// (1 to 15) on rsp_ch, walked by the emitter over the cohort index.
// Stalls: while rsp_ch is not ready the emitter holds its result and the
// front keeps taking events until the queue is full; then req_ch.ready drops.
// Reset: registers return to coordinator, one cohort, 4000 ticks; phase is
// query, counters clear, queue empties and no result is valid.
// ----------------------------------------------------------------------------
module three_phase_commit_engine_top (
   input  logic      clock,
   input  logic      reset,
   tpc_req_if.sink   req_ch,
   tpc_rsp_if.source rsp_ch,
   tpc_csr_if.sink   csr_ch
);
   import tpc_pkg::*;

   logic    q_push, q_pop, q_full, q_empty;
   cmd_type push_cmd, pop_cmd;

   tpc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   tpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   tpc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // status results always stand alone
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.send_valid |-> rsp_ch.last)
      else $error("status result without last");

   // messages to the coordinator are single sends, never part of a broadcast
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.send_valid && rsp_ch.send_to == COORD_NODE |-> rsp_ch.last)
      else $error("send to coordinator not marked last");

   // nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   // a broadcast walks the cohorts in order without skipping
   a_bcast_step: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.send_valid && !rsp_ch.last
      |=> rsp_ch.valid && rsp_ch.send_to == $past(rsp_ch.send_to) + 4'd1)
      else $error("broadcast index did not advance by one");

endmodule

// ===== bench/tb_commit_pkg.sv =====
// ----------------------------------------------------------------------------
// tb_commit_pkg
// Event and result types plus the scoreboard of the commit engine bench.
// The scoreboard keeps its own copy of the registers and the node context,
// predicts the results of every accepted event and checks returned results
// in order.
// ----------------------------------------------------------------------------
package tb_commit_pkg;
   import tpc_pkg::*;

   // codes the engine has no name for but that the fields still allow
   localparam logic [ACT_W-1:0]      ACT_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [TAG_W-1:0]  tag;
      logic [NODE_W-1:0] source;
   } commit_event_type;

   typedef struct packed {
      logic               send_valid;
      logic [TAG_W-1:0]   send_tag;
      logic [NODE_W-1:0]  send_to;
      logic [PHASE_W-1:0] node_state;
      logic               last;
   } commit_result_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [CNT_W-1:0]   acks;
      logic [TIMER_W-1:0] timer;
   } node_ctx_type;

   class commit_scoreboard;
      logic               role;
      logic [CNT_W-1:0]   cohorts;
      logic [TICK_W-1:0]  timeout;
      node_ctx_type       ctx;
      commit_result_type  burst_q[$];
      commit_result_type  pending_results[$];
      int                 errors;
      int                 events_seen;
      int                 results_seen;
      int                 widest;

      function new();
         role         = ROLE_COORD;
         cohorts      = COHORT_RESET;
         timeout      = TICKS_RESET;
         ctx.phase    = PH_QUERY;
         ctx.acks     = '0;
         ctx.timer    = '0;
         errors       = 0;
         events_seen  = 0;
         results_seen = 0;
         widest       = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ROLE:          role    = value[0];
            CSR_COHORT_COUNT:  cohorts = value[CNT_W-1:0];
            CSR_TIMEOUT_TICKS: timeout = value[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      // zero counts as one; four bits already cap it at MAX_NODES - 1
      function int unsigned eff_cohorts();
         return (cohorts == 0) ? 1 : int'(cohorts);
      endfunction

      function void emit(logic sv, logic [TAG_W-1:0] tag, logic [NODE_W-1:0] to,
                         logic [PHASE_W-1:0] st, logic last);
         burst_q.push_back({sv, tag, to, st, last});
      endfunction

      function void post_status(node_ctx_type c);
         emit(1'b0, '0, '0, c.phase, 1'b1);
      endfunction

      function void enter_phase(inout node_ctx_type c, input logic [PHASE_W-1:0] p);
         c.phase = p;
         c.acks  = '0;
         c.timer = '0;
      endfunction

      function void broadcast(inout node_ctx_type c, input logic [TAG_W-1:0] tag,
                              input logic [PHASE_W-1:0] next);
         int unsigned n;
         n = eff_cohorts();
         enter_phase(c, next);
         for (int unsigned i = 1; i <= n; i++)
            emit(1'b1, tag, NODE_W'(i), c.phase, i == n);
      endfunction

      // one event against context c; the results land in burst_q
      function void advance_node(commit_event_type ev, inout node_ctx_type c);
         logic [TAG_W-1:0]   want_tag;
         logic [TAG_W-1:0]   bcast_tag;
         logic [PHASE_W-1:0] next_phase;
         int unsigned        limit;
         burst_q.delete();
         want_tag   = (c.phase == PH_WAITING) ? TAG_VOTE_YES : TAG_ACK;
         bcast_tag  = (c.phase == PH_WAITING) ? TAG_PREPARE : TAG_COMMIT;
         next_phase = (c.phase == PH_WAITING) ? PH_PRECOMMIT : PH_COMMIT;
         limit      = int'(timeout) * eff_cohorts();
         if (role == ROLE_COORD) begin
            if (c.phase == PH_QUERY && ev.action == ACT_START) begin
               broadcast(c, TAG_CAN_COMMIT, PH_WAITING);
            end else if (!(c.phase == PH_WAITING || c.phase == PH_PRECOMMIT)) begin
               post_status(c);
            end else if (ev.action == ACT_MSG && ev.tag == want_tag) begin
               c.acks = c.acks + 1'b1;
               if (c.acks >= eff_cohorts()) broadcast(c, bcast_tag, next_phase);
               else post_status(c);
            end else if (ev.action == ACT_MSG && ev.tag == TAG_ABORT) begin
               broadcast(c, TAG_ABORT, PH_ABORT);
            end else if (ev.action == ACT_TICK) begin
               c.timer = c.timer + 1'b1;
               if (c.timer >= limit) broadcast(c, TAG_ABORT, PH_ABORT);
               else post_status(c);
            end else begin
               post_status(c);
            end
         end else begin
            if (!(c.phase == PH_QUERY || c.phase == PH_WAITING || c.phase == PH_PRECOMMIT)) begin
               post_status(c);
            end else if (ev.action == ACT_MSG) begin
               // a cohort listens to the coordinator only
               if (ev.source != COORD_NODE) begin
                  post_status(c);
               end else if (ev.tag == TAG_ABORT) begin
                  enter_phase(c, PH_ABORT);
                  post_status(c);
               end else if (c.phase == PH_QUERY && ev.tag == TAG_CAN_COMMIT) begin
                  enter_phase(c, PH_WAITING);
                  emit(1'b1, TAG_VOTE_YES, COORD_NODE, c.phase, 1'b1);
               end else if (c.phase == PH_WAITING && ev.tag == TAG_PREPARE) begin
                  enter_phase(c, PH_PRECOMMIT);
                  emit(1'b1, TAG_ACK, COORD_NODE, c.phase, 1'b1);
               end else if (c.phase == PH_PRECOMMIT && ev.tag == TAG_COMMIT) begin
                  enter_phase(c, PH_COMMIT);
                  post_status(c);
               end else begin
                  post_status(c);
               end
            end else if (ev.action == ACT_TICK) begin
               c.timer = c.timer + 1'b1;
               // precommit times out into commit, the others into abort
               if (c.timer >= timeout)
                  enter_phase(c, (c.phase == PH_PRECOMMIT) ? PH_COMMIT : PH_ABORT);
               post_status(c);
            end else begin
               post_status(c);
            end
         end
      endfunction

      function bit stays_in_phase(commit_event_type ev);
         node_ctx_type probe;
         probe = ctx;
         advance_node(ev, probe);
         return probe.phase == ctx.phase;
      endfunction

      function void note_event(commit_event_type ev);
         advance_node(ev, ctx);
         foreach (burst_q[i]) pending_results.push_back(burst_q[i]);
         if (burst_q.size() > widest) widest = burst_q.size();
         events_seen++;
      endfunction

      function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
         if (exp_v !== got_v) begin
            errors++;
            $display("%0t ERROR %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
         end
      endfunction

      function void check_result(commit_result_type got);
         commit_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t ERROR result with nothing expected: actual %h", $time, got);
            return;
         end
         want = pending_results.pop_front();
         compare_field("send_valid", want.send_valid, got.send_valid);
         compare_field("send_tag", want.send_tag, got.send_tag);
         compare_field("send_to", want.send_to, got.send_to);
         compare_field("node_state", want.node_state, got.node_state);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

endpackage

// ===== bench/tb_three_phase_commit_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_three_phase_commit_engine_top
// Bench for one node of the three-phase commit engine. It walks the node
// through query, waiting, precommit and commit, switching role and register
// values between stages, with random events that hold each phase and random
// gaps and stalls on both channels. Every result is checked in order against
// the scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_three_phase_commit_engine_top;
   import tpc_pkg::*;
   import tb_commit_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int DRAIN_PAUSE     = 4;
   localparam int TAIL_CYCLES     = 8;

   logic clock = 1'b0;
   logic reset;

   tpc_req_if req_bus ();
   tpc_rsp_if rsp_bus ();
   tpc_csr_if csr_bus ();

   three_phase_commit_engine_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   commit_scoreboard sb;
   bit rsp_hold_req = 1'b0;
   int send_steady  = 0;
   int reg_writes   = 0;
   int quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic commit_event_type make_event(logic [ACT_W-1:0] a, logic [TAG_W-1:0] t,
                                                   logic [NODE_W-1:0] s);
      return {a, t, s};
   endfunction

   // random event that leaves the phase alone; want is the tag this phase counts
   function automatic commit_event_type pick_event(logic [TAG_W-1:0] want);
      commit_event_type ev;
      for (int tries = 0; tries < 16; tries++) begin
         ev = make_event(ACT_W'($urandom_range(0, 3)), TAG_W'($urandom_range(0, 7)),
                         NODE_W'($urandom_range(0, 15)));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               ev.action = ACT_MSG;
               ev.tag    = want;
            end
            4, 5, 6: ev.action = ACT_TICK;
            default: ;
         endcase
         if (sb.stays_in_phase(ev)) return ev;
      end
      ev.action = ACT_UNUSED;
      return ev;
   endfunction

   task automatic idle_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   task automatic send_event(commit_event_type ev);
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.action     <= ev.action;
      req_bus.msg_tag    <= ev.tag;
      req_bus.msg_source <= ev.source;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_event(ev);
   endtask

   task automatic send_paced(commit_event_type ev);
      send_event(ev);
      if (send_steady > 0) send_steady--;
      else if ($urandom_range(0, 29) == 0) send_steady = 40;
      else if ($urandom_range(0, 2) == 0) idle_req(pick_gap());
   endtask

   task automatic run_stage(int count, logic [TAG_W-1:0] want);
      repeat (count) send_paced(pick_event(want));
   endtask

   // stop sending and let every expected result drain out
   task automatic settle();
      idle_req(1);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic set_register(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      settle();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      sb.write_reg(idx, value);
      reg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // result side pacing; a hold request stalls it for a long stretch
   initial begin : rsp_pacing
      int gap_left;
      int steady_left;
      int hold_left;
      gap_left    = 0;
      steady_left = 0;
      hold_left   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            hold_left    = RSP_HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (steady_left > 0) steady_left--;
            else if ($urandom_range(0, 49) == 0) steady_left = 80;
            else if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result({rsp_bus.send_valid, rsp_bus.send_tag, rsp_bus.send_to,
                          rsp_bus.node_state, rsp_bus.last});
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ERROR no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("three_phase_commit_engine_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      sb = new();
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_START;
      req_bus.msg_tag    <= TAG_CAN_COMMIT;
      req_bus.msg_source <= COORD_NODE;
      csr_bus.valid      <= 1'b0;
      csr_bus.addr       <= CSR_ROLE;
      csr_bus.data       <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // coordinator in query with reset registers: only start does anything
      send_paced(make_event(ACT_TICK, TAG_CAN_COMMIT, COORD_NODE));
      for (int t = 0; t < 8; t++)
         send_paced(make_event(ACT_MSG, TAG_W'(t), NODE_W'(2 * t + 1)));
      send_paced(make_event(ACT_UNUSED, 3'd7, 4'd15));
      send_paced(make_event(ACT_MSG, TAG_ABORT, COORD_NODE));

      // cohort in query: a start, a request from a stranger, an early prepare
      set_register(CSR_ROLE, 16'd1);
      set_register(CSR_TIMEOUT_TICKS, 16'hFFFF);
      send_paced(make_event(ACT_START, TAG_CAN_COMMIT, COORD_NODE));
      send_paced(make_event(ACT_MSG, TAG_CAN_COMMIT, 4'd15));
      send_paced(make_event(ACT_MSG, TAG_PREPARE, COORD_NODE));
      run_stage(40, TAG_CAN_COMMIT);

      // back to coordinator (upper data bits are dropped), zero cohorts
      set_register(CSR_ROLE, 16'h0002);
      set_register(CSR_COHORT_COUNT, 16'd0);
      run_stage(30, TAG_VOTE_YES);

      // widest broadcast, then agreed votes short of the full count
      set_register(CSR_COHORT_COUNT, 16'd15);
      send_paced(make_event(ACT_START, TAG_CAN_COMMIT, COORD_NODE));
      run_stage(25, TAG_VOTE_YES);
      rsp_hold_req = 1'b1;
      repeat (12) send_event(pick_event(TAG_VOTE_YES));
      run_stage(25, TAG_VOTE_YES);

      set_register(CSR_ROLE, 16'd1);
      run_stage(40, TAG_PREPARE);

      // zero cohorts reads as one, so the next vote completes the round
      set_register(CSR_ROLE, 16'd0);
      set_register(CSR_COHORT_COUNT, 16'd0);
      send_paced(make_event(ACT_MSG, TAG_VOTE_YES, 4'd7));

      // precommit with a short limit of timeout times cohorts
      set_register(CSR_COHORT_COUNT, 16'd9);
      set_register(CSR_TIMEOUT_TICKS, 16'd3);
      run_stage(30, TAG_ACK);
      settle();
      set_register(CSR_TIMEOUT_TICKS, 16'd1);
      run_stage(30, TAG_ACK);

      set_register(CSR_ROLE, 16'd1);
      set_register(CSR_TIMEOUT_TICKS, 16'hFFFF);
      run_stage(40, TAG_COMMIT);

      // zero timeout: the first tick expires, and a cohort in precommit commits
      set_register(CSR_TIMEOUT_TICKS, 16'd0);
      send_paced(make_event(ACT_TICK, TAG_CAN_COMMIT, COORD_NODE));
      run_stage(30, TAG_COMMIT);
      set_register(CSR_ROLE, 16'd0);
      set_register(CSR_UNUSED, 16'hFFFF);
      set_register(CSR_COHORT_COUNT, 16'd15);
      run_stage(30, TAG_VOTE_YES);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d events, %0d results and %0d register writes.",
               sb.events_seen, sb.results_seen, reg_writes);
      $display("Node finished in phase %0d; widest burst was %0d results.",
               sb.ctx.phase, sb.widest);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("three_phase_commit_engine_top test passed");
      else
         $display("three_phase_commit_engine_top test failed");
      $finish;
   end

endmodule
